// ===== sv/xpf_pkg.sv =====
`timescale 1ns / 1ps
package xpf_pkg;

    localparam int BUFFER_BYTES = 512;
    localparam int BUF_WORDS    = BUFFER_BYTES / 8;
    localparam int WADDR_W      = $clog2(BUF_WORDS);
    localparam int LEN_W        = 10;
    localparam int IDX_W        = 10;
    localparam int POS_W        = 11;
    localparam int NWORD_W      = 8;

    localparam logic [LEN_W-1:0] HDR_BYTES    = 10'd10;
    localparam logic [15:0]      RTP_HDR_SIZE = 16'd12;
    localparam logic [7:0]       WINDOW_RESET = 8'd128;
    localparam logic [IDX_W-1:0] INDEX_MAX    = 10'd1023;

    typedef enum logic [1:0] {
        REQ_HEADER  = 2'd0,
        REQ_PAYLOAD = 2'd1,
        REQ_EMIT    = 2'd2,
        REQ_NOP     = 2'd3
    } t_req;

    typedef struct packed {
        t_req        op;
        logic [63:0] hdr;
        logic [15:0] len16;
        logic [15:0] seq;
        logic [7:0]  pbyte;
    } t_item;

    typedef struct packed {
        logic  valid;
        t_item item;
    } t_queue_head;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_RD,
        BS_WR,
        BS_ERD,
        BS_EOUT
    } t_bstate;

endpackage

// ===== sv/xpf_req_if.sv =====
`timescale 1ns / 1ps
interface xpf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [63:0] header_bytes;
    logic [15:0] packet_size;
    logic [15:0] seq_number;
    logic [7:0]  payload_byte;
    logic        payload_last;

    modport source (output valid, req_type, header_bytes, packet_size, seq_number,
                    payload_byte, payload_last, input ready);
    modport sink (input valid, req_type, header_bytes, packet_size, seq_number,
                  payload_byte, payload_last, output ready);
endinterface

// ===== sv/xpf_res_if.sv =====
`timescale 1ns / 1ps
interface xpf_res_if;
    logic        valid;
    logic        ready;
    logic [63:0] parity_word;
    logic        word_last;
    logic [15:0] base_seq;
    logic        base_seq_valid;
    logic [7:0]  protected_count;
    logic [9:0]  parity_length;
    logic        overflow;

    modport source (output valid, parity_word, word_last, base_seq, base_seq_valid,
                    protected_count, parity_length, overflow, input ready);
    modport sink (input valid, parity_word, word_last, base_seq, base_seq_valid,
                  protected_count, parity_length, overflow, output ready);
endinterface

// ===== sv/xor_parity_fec_accumulator.sv =====
`timescale 1ns / 1ps
// XOR parity accumulator for a window of RTP packets. Send one header request
// per protected packet (eight header bytes and the packet size), then its
// payload bytes one request each; the block XORs them into a 512-byte parity
// buffer held in a 64 x 64-bit RAM and tracks the first sequence number, the
// packet count and the parity length (10 plus the longest payload). When the
// count hits window_size-1 (APB register at address 0, reset 128), the next
// header restarts the window with that packet as the first. An emit request
// streams the buffer as 8-byte words, earliest byte most significant, bytes
// past the parity length zeroed, and then clears the accumulation; an empty
// buffer emits one zero word. Payload bytes past the buffer end are dropped
// and reported through overflow. A front queue of two requests decouples the
// input from the execution unit. Header and payload requests read-modify-write
// the single RAM port through the read and write states (a header twice, one
// word each; a payload byte dropped past the buffer end skips them), and an
// emit reads and outputs each word in turn while the result side keeps up;
// no-op requests are absorbed by the queue. Per-word valid flops make a clear
// take effect at once, so there is no clearing pass after reset.
module xor_parity_fec_accumulator
    import xpf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    xpf_req_if.sink     i_req,
    xpf_res_if.source   o_res,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0]  r_window;
    logic        cfg_wr;
    logic        pop;
    t_queue_head head;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    // window_size register, to be written only while the block is idle; the user must ensure this
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window <= WINDOW_RESET;
        end else if (cfg_wr) begin
            r_window <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == 1'b0) ? {24'd0, r_window} : 32'd0;

    // front: accept, drop no-ops, queue
    xpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_pop   (pop),
        .o_head  (head)
    );

    // back: RMW into the parity RAM, stream on emit
    xpf_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_window (r_window),
        .i_head   (head),
        .o_pop    (pop),
        .o_res    (o_res)
    );
endmodule

// ===== sv/xpf_ram.sv =====
`timescale 1ns / 1ps
module xpf_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== sv/xpf_front.sv =====
`timescale 1ns / 1ps
module xpf_front
    import xpf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    xpf_req_if.sink       i_req,
    input  logic          i_pop,
    output t_queue_head   o_head
);
    t_item      r_slot [2];
    logic       r_wptr, n_wptr;
    logic       r_rptr, n_rptr;
    logic [1:0] r_cnt, n_cnt;
    logic       push;
    t_item      in_item;

    assign i_req.ready = (r_cnt != 2'd2);

    // classify: no-op requests are taken and dropped here
    assign push = i_req.valid && i_req.ready && (t_req'(i_req.req_type) != REQ_NOP);

    always_comb begin
        in_item.op    = t_req'(i_req.req_type);
        in_item.hdr   = i_req.header_bytes;
        in_item.len16 = i_req.packet_size - RTP_HDR_SIZE;
        in_item.seq   = i_req.seq_number;
        in_item.pbyte = i_req.payload_byte;
    end

    always_comb begin
        n_wptr = r_wptr ^ push;
        n_rptr = r_rptr ^ i_pop;
        n_cnt  = r_cnt + {1'b0, push} - {1'b0, i_pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= 1'b0;
            r_rptr <= 1'b0;
            r_cnt  <= 2'd0;
        end else begin
            r_wptr <= n_wptr;
            r_rptr <= n_rptr;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wptr] <= in_item;
        end
    end

    assign o_head.valid = (r_cnt != 2'd0);
    assign o_head.item  = r_slot[r_rptr];
endmodule

// ===== sv/xpf_back.sv =====
`timescale 1ns / 1ps
module xpf_back
    import xpf_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic [7:0]   i_window,
    input  t_queue_head  i_head,
    output logic         o_pop,
    xpf_res_if.source    o_res
);
    t_bstate               r_state, n_state;
    logic [7:0]            r_count, n_count;
    logic [15:0]           r_fseq, n_fseq;
    logic                  r_fsv, n_fsv;
    logic [LEN_W-1:0]      r_len, n_len;
    logic [IDX_W-1:0]      r_idx, n_idx;
    logic                  r_drop, n_drop;
    logic [BUF_WORDS-1:0]  r_wvalid, n_wvalid;
    logic [WADDR_W-1:0]    r_addr, n_addr;
    logic [63:0]           r_mask, n_mask;
    logic [15:0]           r_hdr2, n_hdr2;
    logic                  r_is_hdr, n_is_hdr;

    logic                  r_ovalid, n_ovalid;
    logic [63:0]           r_oword, n_oword;
    logic                  r_olast, n_olast;
    logic [15:0]           r_oseq, n_oseq;
    logic                  r_osv, n_osv;
    logic [7:0]            r_ocnt, n_ocnt;
    logic [LEN_W-1:0]      r_olen, n_olen;
    logic                  r_oovf, n_oovf;

    logic                  we;
    logic [63:0]           wdata;
    logic [63:0]           rdata;
    logic [63:0]           old_word;
    logic [63:0]           emit_word;
    logic [NWORD_W-1:0]    words;
    logic                  emit_last;
    logic [7:0]            cnt1;
    logic                  win_clr;
    logic [LEN_W-1:0]      len_base;
    logic [POS_W-1:0]      pos;
    logic [LEN_W-1:0]      pos1;
    logic [LEN_W-1:0]      lane_pos;

    xpf_ram #(.WIDTH(64), .DEPTH(BUF_WORDS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_addr),
        .i_wdata (wdata),
        .i_raddr (r_addr),
        .o_rdata (rdata)
    );

    // never-written words read as zero
    assign old_word = r_wvalid[r_addr] ? rdata : 64'd0;
    assign wdata    = old_word ^ r_mask;

    always_comb begin
        words = NWORD_W'((11'(r_len) + 11'd7) >> 3);
        if (words == '0) begin
            words = NWORD_W'(1);
        end
        emit_last = ((NWORD_W'(r_addr) + NWORD_W'(1)) == words);
        for (int b = 0; b < 8; b++) begin
            lane_pos = LEN_W'({r_addr, 3'(b)});
            emit_word[63-8*b -: 8] = (lane_pos < r_len) ? old_word[63-8*b -: 8] : 8'd0;
        end
    end

    assign cnt1    = r_count + 8'd1;
    assign win_clr = (cnt1 == i_window);
    assign pos     = POS_W'(HDR_BYTES) + POS_W'(r_idx);
    assign pos1    = LEN_W'(pos) + LEN_W'(1);
    assign len_base = win_clr ? '0 : r_len;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_fseq   = r_fseq;
        n_fsv    = r_fsv;
        n_len    = r_len;
        n_idx    = r_idx;
        n_drop   = r_drop;
        n_wvalid = r_wvalid;
        n_addr   = r_addr;
        n_mask   = r_mask;
        n_hdr2   = r_hdr2;
        n_is_hdr = r_is_hdr;
        n_ovalid = r_ovalid && !o_res.ready;
        n_oword  = r_oword;
        n_olast  = r_olast;
        n_oseq   = r_oseq;
        n_osv    = r_osv;
        n_ocnt   = r_ocnt;
        n_olen   = r_olen;
        n_oovf   = r_oovf;
        o_pop    = 1'b0;
        we       = 1'b0;

        unique case (r_state)
            BS_IDLE: begin
                if (i_head.valid) begin
                    o_pop = 1'b1;
                    unique case (i_head.item.op)
                        REQ_HEADER: begin
                            n_count = win_clr ? 8'd1 : cnt1;
                            if (win_clr) begin
                                n_wvalid = '0;
                                n_drop   = 1'b0;
                            end
                            n_len = (len_base < HDR_BYTES) ? HDR_BYTES : len_base;
                            if (win_clr || !r_fsv) begin
                                n_fseq = i_head.item.seq;
                            end
                            n_fsv    = 1'b1;
                            n_idx    = '0;
                            n_addr   = '0;
                            n_mask   = i_head.item.hdr;
                            n_hdr2   = i_head.item.len16;
                            n_is_hdr = 1'b1;
                            n_state  = BS_RD;
                        end
                        REQ_PAYLOAD: begin
                            if (pos < POS_W'(BUFFER_BYTES)) begin
                                n_addr   = pos[WADDR_W+2:3];
                                n_mask   = {56'd0, i_head.item.pbyte} << {~pos[2:0], 3'b000};
                                n_is_hdr = 1'b0;
                                if (r_len < pos1) begin
                                    n_len = pos1;
                                end
                                n_state = BS_RD;
                            end else begin
                                n_drop = 1'b1;
                            end
                            if (r_idx != INDEX_MAX) begin
                                n_idx = r_idx + IDX_W'(1);
                            end
                        end
                        REQ_EMIT: begin
                            n_addr  = '0;
                            n_state = BS_ERD;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            BS_RD: begin
                n_state = BS_WR;
            end
            BS_WR: begin
                we               = 1'b1;
                n_wvalid[r_addr] = 1'b1;
                if (r_is_hdr) begin
                    // second header word: length field lands in bytes 8 and 9
                    n_addr   = WADDR_W'(1);
                    n_mask   = {r_hdr2, 48'd0};
                    n_is_hdr = 1'b0;
                    n_state  = BS_RD;
                end else begin
                    n_state = BS_IDLE;
                end
            end
            BS_ERD: begin
                n_state = BS_EOUT;
            end
            BS_EOUT: begin
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid = 1'b1;
                    n_oword  = emit_word;
                    n_olast  = emit_last;
                    n_oseq   = r_fseq;
                    n_osv    = r_fsv;
                    n_ocnt   = r_count;
                    n_olen   = r_len;
                    n_oovf   = r_drop;
                    if (emit_last) begin
                        n_wvalid = '0;
                        n_count  = '0;
                        n_fseq   = '0;
                        n_fsv    = 1'b0;
                        n_len    = '0;
                        n_idx    = '0;
                        n_drop   = 1'b0;
                        n_state  = BS_IDLE;
                    end else begin
                        n_addr  = r_addr + WADDR_W'(1);
                        n_state = BS_ERD;
                    end
                end
            end
            default: begin
                n_state = BS_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= BS_IDLE;
            r_count  <= '0;
            r_fseq   <= '0;
            r_fsv    <= 1'b0;
            r_len    <= '0;
            r_idx    <= '0;
            r_drop   <= 1'b0;
            r_wvalid <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_fseq   <= n_fseq;
            r_fsv    <= n_fsv;
            r_len    <= n_len;
            r_idx    <= n_idx;
            r_drop   <= n_drop;
            r_wvalid <= n_wvalid;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr   <= n_addr;
        r_mask   <= n_mask;
        r_hdr2   <= n_hdr2;
        r_is_hdr <= n_is_hdr;
        r_oword  <= n_oword;
        r_olast  <= n_olast;
        r_oseq   <= n_oseq;
        r_osv    <= n_osv;
        r_ocnt   <= n_ocnt;
        r_olen   <= n_olen;
        r_oovf   <= n_oovf;
    end

    assign o_res.valid           = r_ovalid;
    assign o_res.parity_word     = r_oword;
    assign o_res.word_last       = r_olast;
    assign o_res.base_seq        = r_oseq;
    assign o_res.base_seq_valid  = r_osv;
    assign o_res.protected_count = r_ocnt;
    assign o_res.parity_length   = r_olen;
    assign o_res.overflow        = r_oovf;
endmodule
